// ===== rtl/stt_pkg.sv =====
// Shared types, constants and byte classification for the source text tokenizer.
package stt_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int KIND_BITS       = 5;
   localparam int OUT_OFFSET_BITS = 24;
   localparam int LINE_BITS       = 20;
   localparam int COL_BITS        = 16;
   localparam int REC_QUEUE_DEPTH = 4;

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [COL_BITS-1:0]  COL_MAX  = '1;

   localparam logic [BYTE_BITS-1:0] CHR_NL     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHR_TAB    = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHR_HIGH   = 8'h80;
   localparam logic [BYTE_BITS-1:0] CHR_SEMI   = 8'h3B;
   localparam logic [BYTE_BITS-1:0] CHR_MINUS  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHR_LT     = 8'h3C;
   localparam logic [BYTE_BITS-1:0] CHR_GT     = 8'h3E;
   localparam logic [BYTE_BITS-1:0] CHR_UNDER  = 8'h5F;
   localparam logic [BYTE_BITS-1:0] CHR_0      = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHR_9      = 8'h39;
   localparam logic [BYTE_BITS-1:0] CHR_UPPA   = 8'h41;
   localparam logic [BYTE_BITS-1:0] CHR_UPPZ   = 8'h5A;
   localparam logic [BYTE_BITS-1:0] CHR_LPAREN = 8'h28;
   localparam logic [BYTE_BITS-1:0] CHR_RPAREN = 8'h29;
   localparam logic [BYTE_BITS-1:0] CHR_LBRACK = 8'h5B;
   localparam logic [BYTE_BITS-1:0] CHR_RBRACK = 8'h5D;
   localparam logic [BYTE_BITS-1:0] CHR_LBRACE = 8'h7B;
   localparam logic [BYTE_BITS-1:0] CHR_RBRACE = 8'h7D;
   localparam logic [BYTE_BITS-1:0] CHR_QUERY  = 8'h3F;
   localparam logic [BYTE_BITS-1:0] CHR_COLON  = 8'h3A;
   localparam logic [BYTE_BITS-1:0] CHR_EQUALS = 8'h3D;
   localparam logic [BYTE_BITS-1:0] CHR_AMP    = 8'h26;
   localparam logic [BYTE_BITS-1:0] CHR_BAR    = 8'h7C;
   localparam logic [BYTE_BITS-1:0] CHR_BANG   = 8'h21;
   localparam logic [BYTE_BITS-1:0] CHR_DOT    = 8'h2E;
   localparam logic [BYTE_BITS-1:0] CHR_COMMA  = 8'h2C;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LPAREN = 5'd0,
      KIND_LBRACKET,
      KIND_LBRACE,
      KIND_RPAREN,
      KIND_RBRACKET,
      KIND_RBRACE,
      KIND_QUERY,
      KIND_COLON,
      KIND_EQUALS,
      KIND_AMP,
      KIND_BAR,
      KIND_BANG,
      KIND_SEMI,
      KIND_COMMENT,
      KIND_DOT,
      KIND_COMMA,
      KIND_ARROW,
      KIND_CONJ,
      KIND_TYPE_ID,
      KIND_ID,
      KIND_NUMBER
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ID,
      MODE_TYPE_ID,
      MODE_NUMBER,
      MODE_COMMENT
   } mode_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] text_byte;
      logic                 final_byte;
   } in_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]       token_kind;
      logic [OUT_OFFSET_BITS-1:0] start_offset;
      logic [LINE_BITS-1:0]       start_line;
      logic [COL_BITS-1:0]        start_column;
      logic                       run_end;
   } out_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0]  column;
   } pos_type;

   // records raised by one item, in order; count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      out_type    first;
      out_type    second;
   } emit_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } single_type;

   function automatic single_type single_kind(input logic [BYTE_BITS-1:0] b);
      single_type r;
      r.hit  = 1'b1;
      r.kind = KIND_LPAREN;
      case (b)
         CHR_LPAREN: r.kind = KIND_LPAREN;
         CHR_LBRACK: r.kind = KIND_LBRACKET;
         CHR_LBRACE: r.kind = KIND_LBRACE;
         CHR_RPAREN: r.kind = KIND_RPAREN;
         CHR_RBRACK: r.kind = KIND_RBRACKET;
         CHR_RBRACE: r.kind = KIND_RBRACE;
         CHR_QUERY:  r.kind = KIND_QUERY;
         CHR_COLON:  r.kind = KIND_COLON;
         CHR_EQUALS: r.kind = KIND_EQUALS;
         CHR_AMP:    r.kind = KIND_AMP;
         CHR_BAR:    r.kind = KIND_BAR;
         CHR_BANG:   r.kind = KIND_BANG;
         CHR_DOT:    r.kind = KIND_DOT;
         CHR_COMMA:  r.kind = KIND_COMMA;
         default:    r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_delim(input logic [BYTE_BITS-1:0] b);
      logic d;
      d = (b <= CHR_SPACE) || (b >= CHR_HIGH) ||
          (b inside {CHR_LPAREN, CHR_RPAREN, CHR_LBRACK, CHR_RBRACK, CHR_LBRACE,
                     CHR_RBRACE, CHR_COLON, CHR_SEMI, CHR_DOT, CHR_COMMA, CHR_QUERY});
      return d;
   endfunction

endpackage

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer top level: byte in, token-start records out.
//
// Takes one byte of source text per cycle and returns a record (kind, offset,
// line, column) for each token start; a byte raises zero, one or two records,
// and run_end marks the last record of each byte. Scanning is a single
// registered pass: the byte meets the scan state and the position counters
// combinationally and its records go into a four-entry queue, so a byte is taken
// every cycle while the queue has room for two records. The queue drains one
// record per cycle while rsp_ready is high, so the sustained rate is one byte
// per cycle as long as the text averages at most one token start per byte. A
// lookahead byte for "->", "<>" and ";;" is resolved by the next byte or by
// final_byte.
module source_text_tokenizer #(
   parameter int OFFSET_BITS = 24,
   parameter int TAB_STOP    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::in_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::out_type rsp_data
);
   import stt_pkg::*;

   logic                   step;
   logic [OFFSET_BITS-1:0] offset;
   pos_type                pos;
   emit_type               emit;

   assign step = req_valid && req_ready;

   stt_position #(
      .OFFSET_BITS(OFFSET_BITS),
      .TAB_STOP   (TAB_STOP)
   ) u_position (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .text_byte(req_data.text_byte),
      .offset   (offset),
      .pos      (pos)
   );

   stt_lexer #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_lexer (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (req_data),
      .offset(offset),
      .pos   (pos),
      .emit  (emit)
   );

   stt_rec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .emit      (emit),
      .pop       (rsp_valid && rsp_ready),
      .space_ok  (req_ready),
      .head_valid(rsp_valid),
      .head      (rsp_data)
   );

endmodule

// ===== rtl/stt_position.sv =====
// Byte offset, line and column counters with tab stops and saturation.
module stt_position #(
   parameter int OFFSET_BITS = 24,
   parameter int TAB_STOP    = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [stt_pkg::BYTE_BITS-1:0] text_byte,
   output logic [OFFSET_BITS-1:0]        offset,
   output stt_pkg::pos_type              pos
);
   import stt_pkg::*;

   localparam int MOD_BITS    = $clog2(TAB_STOP);
   localparam int COL_MAX_MOD = int'(COL_MAX) % TAB_STOP;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [MOD_BITS-1:0]    mod_ff, mod_in;   // column modulo the tab stop
   logic [COL_BITS:0]      col_inc, tab_target;

   assign col_inc    = {1'b0, col_ff} + (COL_BITS+1)'(1);
   assign tab_target = {1'b0, col_ff} - (COL_BITS+1)'(mod_ff) + (COL_BITS+1)'(TAB_STOP)
                       + (COL_BITS+1)'(1);

   always_comb begin
      offset_in = offset_ff + OFFSET_BITS'(1);
      line_in   = line_ff;
      col_in    = col_ff;
      mod_in    = mod_ff;
      if (text_byte == CHR_NL) begin
         if (line_ff != LINE_MAX) line_in = line_ff + LINE_BITS'(1);
         col_in = COL_BITS'(1);
         mod_in = MOD_BITS'(1);
      end else if (text_byte == CHR_TAB) begin
         if (tab_target > {1'b0, COL_MAX}) begin
            col_in = COL_MAX;
            mod_in = MOD_BITS'(COL_MAX_MOD);
         end else begin
            col_in = tab_target[COL_BITS-1:0];
            mod_in = MOD_BITS'(1);
         end
      end else begin
         if (col_inc > {1'b0, COL_MAX}) begin
            col_in = COL_MAX;
            mod_in = MOD_BITS'(COL_MAX_MOD);
         end else begin
            col_in = col_inc[COL_BITS-1:0];
            mod_in = (mod_ff == MOD_BITS'(TAB_STOP - 1)) ? '0 : mod_ff + MOD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         line_ff   <= LINE_BITS'(1);
         col_ff    <= COL_BITS'(1);
         mod_ff    <= MOD_BITS'(1);
      end else if (step) begin
         offset_ff <= offset_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         mod_ff    <= mod_in;
      end
   end

   assign offset     = offset_ff;
   assign pos.line   = line_ff;
   assign pos.column = col_ff;

endmodule

// ===== rtl/stt_lexer.sv =====
// Scan mode, one-byte lookahead and token record generation.
module stt_lexer #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  stt_pkg::in_type        item,
   input  logic [OFFSET_BITS-1:0] offset,
   input  stt_pkg::pos_type       pos,
   output stt_pkg::emit_type      emit
);
   import stt_pkg::*;

   mode_type             mode_ff, mode_in, mode_a;
   logic                 held_valid_ff, held_valid_in;
   logic [BYTE_BITS-1:0] held_byte_ff;
   logic [LINE_BITS-1:0] held_line_ff;
   logic [COL_BITS-1:0]  held_col_ff;

   logic [BYTE_BITS-1:0]   b;
   logic [OFFSET_BITS-1:0] hoff;
   logic [31:0]            off_wide, hoff_wide;
   logic                   a_valid, b_valid, consumed, lex;
   kind_type               a_kind, b_kind;
   single_type             sk;
   out_type                rec_a, rec_b;

   assign b         = item.text_byte;
   assign hoff      = offset - OFFSET_BITS'(1);
   assign off_wide  = 32'(offset);
   assign hoff_wide = 32'(hoff);
   assign sk        = single_kind(b);

   always_comb begin
      a_valid       = 1'b0;
      a_kind        = KIND_ID;
      consumed      = 1'b0;
      mode_a        = mode_ff;
      b_valid       = 1'b0;
      b_kind        = KIND_ID;
      held_valid_in = 1'b0;
      lex           = 1'b0;

      if (held_valid_ff) begin
         a_valid = 1'b1;
         if (held_byte_ff == CHR_SEMI && b == CHR_SEMI) begin
            a_kind   = KIND_COMMENT;
            mode_a   = MODE_COMMENT;
            consumed = 1'b1;
         end else if (held_byte_ff == CHR_MINUS && b == CHR_GT) begin
            a_kind   = KIND_ARROW;
            mode_a   = MODE_IDLE;
            consumed = 1'b1;
         end else if (held_byte_ff == CHR_LT && b == CHR_GT) begin
            a_kind   = KIND_CONJ;
            mode_a   = MODE_IDLE;
            consumed = 1'b1;
         end else if (held_byte_ff == CHR_SEMI) begin
            a_kind = KIND_SEMI;
            mode_a = MODE_IDLE;
         end else begin
            a_kind = KIND_ID;
            mode_a = MODE_ID;
         end
      end

      mode_in = mode_a;
      if (!consumed) begin
         case (mode_a)
            MODE_COMMENT: begin
               if (b == CHR_NL) mode_in = MODE_IDLE;
            end
            MODE_ID, MODE_TYPE_ID: lex = is_delim(b);
            MODE_NUMBER:           lex = !((b inside {[CHR_0:CHR_9]}) || b == CHR_UNDER);
            default:               lex = 1'b1;
         endcase
         if (lex) begin
            mode_in = MODE_IDLE;
            if (sk.hit) begin
               b_valid = 1'b1;
               b_kind  = sk.kind;
            end else if (b inside {CHR_SEMI, CHR_MINUS, CHR_LT}) begin
               held_valid_in = 1'b1;
            end else if (b inside {[CHR_UPPA:CHR_UPPZ]}) begin
               b_valid = 1'b1;
               b_kind  = KIND_TYPE_ID;
               mode_in = MODE_TYPE_ID;
            end else if (b inside {[CHR_0:CHR_9]}) begin
               b_valid = 1'b1;
               b_kind  = KIND_NUMBER;
               mode_in = MODE_NUMBER;
            end else if (b > CHR_SPACE && b < CHR_HIGH) begin
               b_valid = 1'b1;
               b_kind  = KIND_ID;
               mode_in = MODE_ID;
            end
         end
      end

      // last byte of the text: a fresh lookahead resolves as a lone byte
      if (item.final_byte) begin
         if (held_valid_in) begin
            b_valid = 1'b1;
            b_kind  = (b == CHR_SEMI) ? KIND_SEMI : KIND_ID;
         end
         held_valid_in = 1'b0;
         mode_in       = MODE_IDLE;
      end
   end

   always_comb begin
      rec_a.token_kind   = a_kind;
      rec_a.start_offset = hoff_wide[OUT_OFFSET_BITS-1:0];
      rec_a.start_line   = held_line_ff;
      rec_a.start_column = held_col_ff;
      rec_a.run_end      = !b_valid;
      rec_b.token_kind   = b_kind;
      rec_b.start_offset = off_wide[OUT_OFFSET_BITS-1:0];
      rec_b.start_line   = pos.line;
      rec_b.start_column = pos.column;
      rec_b.run_end      = 1'b1;
      emit.count         = {1'b0, a_valid} + {1'b0, b_valid};
      emit.first         = a_valid ? rec_a : rec_b;
      emit.second        = rec_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         held_line_ff  <= LINE_BITS'(1);
         held_col_ff   <= COL_BITS'(1);
      end else if (step) begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         if (held_valid_in) begin
            held_byte_ff <= b;
            held_line_ff <= pos.line;
            held_col_ff  <= pos.column;
         end
      end
   end

endmodule

// ===== rtl/stt_rec_fifo.sv =====
// Small record queue taking up to two records a cycle and giving one.
module stt_rec_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stt_pkg::emit_type emit,
   input  logic              pop,
   output logic              space_ok,
   output logic              head_valid,
   output stt_pkg::out_type  head
);
   import stt_pkg::*;

   localparam int PTR_BITS = $clog2(REC_QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(REC_QUEUE_DEPTH + 1);

   out_type             mem_ff [REC_QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_next;
   logic [CNT_BITS-1:0] count_ff, count_in, push_n;

   assign push_n      = push ? CNT_BITS'(emit.count) : '0;
   assign wr_ptr_next = wr_ptr_ff + PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_BITS'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in    = count_ff + push_n - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && emit.count != 2'd0) mem_ff[wr_ptr_ff]   <= emit.first;
      if (push && emit.count == 2'd2) mem_ff[wr_ptr_next] <= emit.second;
   end

   assign space_ok   = count_ff <= CNT_BITS'(REC_QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];

endmodule
